@@ rtl/iorb_pkg.sv @@
package iorb_pkg;

  localparam int WINDOW_DEPTH = 32;
  localparam int SEQ_BITS     = 16;
  localparam int MAX_RESULTS  = 32;
  localparam int WIN_SIZE     = (WINDOW_DEPTH < MAX_RESULTS) ? WINDOW_DEPTH : MAX_RESULTS;
  localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
  localparam int SEQ_ID_W     = 16;
  localparam int WORD_W       = 32;

  localparam logic [1:0] STATUS_RELEASED   = 2'd0;
  localparam logic [1:0] STATUS_OUT_OF_WIN = 2'd1;
  localparam logic [1:0] STATUS_DUPLICATE  = 2'd2;

  typedef logic [SEQ_BITS-1:0] seq_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [WORD_W-1:0]   word_t;

  typedef struct packed {
    seq_t  seq;
    word_t a;
    word_t b;
  } item_t;

endpackage

@@ rtl/iorb_if.sv @@
interface iorb_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] seq_id;
  logic [31:0] payload_a;
  logic [31:0] payload_b;

  modport source (output valid, seq_id, payload_a, payload_b, input ready);
  modport sink   (input valid, seq_id, payload_a, payload_b, output ready);
endinterface

interface iorb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] released_seq;
  logic [31:0] out_a;
  logic [31:0] out_b;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, released_seq, out_a, out_b, status, last, input ready);
  modport sink   (input valid, released_seq, out_a, out_b, status, last, output ready);
endinterface

@@ rtl/iorb_front.sv @@
module iorb_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  iorb_in_if.sink       in_if,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output iorb_pkg::item_t q_item_o
);
  import iorb_pkg::*;

  item_t      data_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  item_t      in_item;

  // tag cast to the sequence width the engine works in
  assign in_item.seq = seq_t'(in_if.seq_id);
  assign in_item.a   = in_if.payload_a;
  assign in_item.b   = in_if.payload_b;

  assign in_if.ready = (count_q != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign q_valid_o   = (count_q != 2'd0);
  assign q_item_o    = data_q[rd_ptr_q];
  assign pop         = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

@@ rtl/iorb_engine.sv @@
module iorb_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  iorb_pkg::item_t q_item_i,
  iorb_out_if.source      out_if
);
  import iorb_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  localparam slot_t               SLOT_LAST = slot_t'(WINDOW_DEPTH - 1);
  localparam logic [SLOT_W:0]     DEPTH_EXT = (SLOT_W + 1)'(WINDOW_DEPTH);
  localparam seq_t                WIN_SEQ   = seq_t'(WIN_SIZE);

  logic                     state_q, state_d;
  seq_t                     expected_q, expected_d;
  slot_t                    head_q, head_d;
  logic [WINDOW_DEPTH-1:0]  valid_q, valid_d;
  logic                     out_valid_q, out_valid_d;

  logic [2*WORD_W-1:0]      mem_q [WINDOW_DEPTH];
  logic [2*WORD_W-1:0]      rd_data_q;

  seq_t                     out_seq_q;
  word_t                    out_a_q, out_b_q;
  logic [1:0]               out_status_q;
  logic                     out_last_q;

  seq_t                     offset;
  logic [SLOT_W:0]          slot_sum;
  slot_t                    slot;
  slot_t                    head_next;
  logic                     in_win, is_head, is_dup, is_store;
  logic                     can_emit, pop, drain_emit, advance;

  always_comb begin
    offset    = q_item_i.seq - expected_q;
    in_win    = (offset < WIN_SEQ);
    // offset is below the window here, so it fits in the slot index width
    slot_sum  = {1'b0, head_q} + {1'b0, offset[SLOT_W-1:0]};
    slot      = (slot_sum >= DEPTH_EXT) ? SLOT_W'(slot_sum - DEPTH_EXT) : SLOT_W'(slot_sum);
    head_next = (head_q == SLOT_LAST) ? '0 : head_q + 1'b1;
    is_head   = in_win && (offset == '0);
    is_dup    = in_win && !is_head && valid_q[slot];
    is_store  = in_win && !is_head && !valid_q[slot];
    can_emit  = !out_valid_q || out_if.ready;
  end

  assign pop        = (state_q == ST_IDLE) && q_valid_i && (is_store || can_emit);
  assign q_ready_o  = (state_q == ST_IDLE) && (is_store || can_emit);
  assign drain_emit = (state_q == ST_DRAIN) && can_emit;
  assign advance    = (pop && is_head) || drain_emit;

  always_comb begin
    state_d     = state_q;
    expected_d  = expected_q;
    head_d      = head_q;
    valid_d     = valid_q;
    out_valid_d = out_if.ready ? 1'b0 : out_valid_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          if (is_store) begin
            valid_d[slot] = 1'b1;
          end else begin
            out_valid_d = 1'b1;
            if (is_head) begin
              expected_d = expected_q + 1'b1;
              head_d     = head_next;
              if (valid_q[head_next]) begin
                state_d = ST_DRAIN;
              end
            end
          end
        end
      end
      ST_DRAIN: begin
        if (drain_emit) begin
          out_valid_d     = 1'b1;
          valid_d[head_q] = 1'b0;
          expected_d      = expected_q + 1'b1;
          head_d          = head_next;
          if (!valid_q[head_next]) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      expected_q  <= '0;
      head_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      expected_q  <= expected_d;
      head_q      <= head_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload store, read ahead at the slot that becomes head
  always_ff @(posedge clk_i) begin
    if (pop && is_store) begin
      mem_q[slot] <= {q_item_i.a, q_item_i.b};
    end
    if (advance) begin
      rd_data_q <= mem_q[head_next];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && !is_store) begin
      out_seq_q <= q_item_i.seq;
      if (is_head) begin
        out_a_q      <= q_item_i.a;
        out_b_q      <= q_item_i.b;
        out_status_q <= STATUS_RELEASED;
        out_last_q   <= !valid_q[head_next];
      end else begin
        out_a_q      <= '0;
        out_b_q      <= '0;
        out_status_q <= is_dup ? STATUS_DUPLICATE : STATUS_OUT_OF_WIN;
        out_last_q   <= 1'b1;
      end
    end else if (drain_emit) begin
      out_seq_q    <= expected_q;
      out_a_q      <= rd_data_q[2*WORD_W-1:WORD_W];
      out_b_q      <= rd_data_q[WORD_W-1:0];
      out_status_q <= STATUS_RELEASED;
      out_last_q   <= !valid_q[head_next];
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.released_seq = SEQ_ID_W'(out_seq_q);
  assign out_if.out_a        = out_a_q;
  assign out_if.out_b        = out_b_q;
  assign out_if.status       = out_status_q;
  assign out_if.last         = out_last_q;

endmodule

@@ rtl/in_order_reorder_buffer_unit.sv @@
// path: an in-order transaction is registered in the two-entry queue, then in the output register
// throughput: one input transaction per cycle into a two-entry queue while not full; the engine takes one per cycle
//   when idle and drains a buffered run from the payload store port at one result per cycle unless the output stalls
// reset: asynchronous, active low; clears the queue, expected number, head slot and slot
//   valid bits; the payload store is not cleared
module in_order_reorder_buffer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  iorb_in_if.sink    in_if,
  iorb_out_if.source out_if
);
  import iorb_pkg::*;

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  iorb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_if    (in_if),
    .q_valid_o(q_valid),
    .q_ready_i(q_ready),
    .q_item_o (q_item)
  );

  iorb_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_ready_o(q_ready),
    .q_item_i (q_item),
    .out_if   (out_if)
  );

endmodule

@@ rtl/iorb_checker.sv @@
module iorb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_seq_i,
  input logic [31:0] out_a_i,
  input logic [31:0] out_b_i,
  input logic [1:0]  out_status_i,
  input logic        out_last_i
);
  import iorb_pkg::*;

  // a stalled result keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_seq_i) && $stable(out_a_i)
      && $stable(out_b_i) && $stable(out_status_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  // a rejection is always a single result
  a_reject_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != STATUS_RELEASED |-> out_last_i)
    else $error("rejection without last");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != STATUS_RELEASED |-> out_a_i == '0 && out_b_i == '0)
    else $error("rejection carries payload");

  // released tags within a run count up by one
  a_run_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_status_i == STATUS_RELEASED && !out_last_i
    ##1 out_valid_i && out_status_i == STATUS_RELEASED
    |-> out_seq_i == 16'($past(out_seq_i) + 16'd1))
    else $error("release run out of order");

endmodule

bind in_order_reorder_buffer_unit iorb_checker u_iorb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_seq_i   (out_if.released_seq),
  .out_a_i     (out_if.out_a),
  .out_b_i     (out_if.out_b),
  .out_status_i(out_if.status),
  .out_last_i  (out_if.last)
);
